### rtl/valid_2d_convolution_macros.svh
// Assertion macros for the checker file of the valid 2D convolution block.
// Depends on nothing; each user supplies clk and rst in its scope.
`ifndef VALID_2D_CONVOLUTION_MACROS_SVH
`define VALID_2D_CONVOLUTION_MACROS_SVH

// Property checked outside reset.
`define VCONV_CHECK(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property that must also hold through reset.
`define VCONV_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/vconv_pkg.sv
// Shared types and constants for the valid 2D convolution block.
// No dependencies.
`default_nettype none
package vconv_pkg;

  localparam int DW      = 16;
  localparam int SUMW    = 38;
  localparam int ROWW    = 10;
  localparam int COLMAXW = 12;
  localparam int CFGW    = 11;
  localparam int CFGIW   = 3;
  localparam int SLOTW   = 6;
  localparam int ROW_LIMIT = 1024;

  typedef enum logic [CFGIW-1:0] {
    CFG_IMAGE_WIDTH   = 3'd0,
    CFG_IMAGE_HEIGHT  = 3'd1,
    CFG_TAPS_WIDE     = 3'd2,
    CFG_TAPS_HIGH     = 3'd3,
    CFG_RESULT_WIDTH  = 3'd4,
    CFG_RESULT_HEIGHT = 3'd5
  } cfg_index_t;

  localparam logic OP_COEF  = 1'b0;
  localparam logic OP_PIXEL = 1'b1;

  typedef logic signed [DW-1:0]   sample_t;
  typedef logic signed [SUMW-1:0] sum_t;

  // Position of a result travelling down the MAC pipeline.
  typedef struct packed {
    logic                valid;
    logic [ROWW-1:0]     row;
    logic [COLMAXW-1:0]  col;
    logic                last;
  } meta_t;

  // Controls from the front stage to the line store and window.
  typedef struct packed {
    logic               pix_we;
    logic               coef_we;
    logic [SLOTW-1:0]   slot;
    logic [COLMAXW-1:0] col;
    sample_t            data;
  } front_t;

endpackage
`default_nettype wire

### rtl/vconv_ram.sv
// Generic simple dual-port RAM with registered read (read-first).
// No dependencies.
`default_nettype none
module vconv_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

### rtl/vconv_window.sv
// Line store (RAM, read-modify-write per column), tap window and coefficient store.
// Depends on vconv_pkg and vconv_ram.
`default_nettype none
module vconv_window #(
  parameter int MAX_LINE_WIDTH = 128,
  parameter int MAX_TAPS       = 7
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              adv,
  input  logic                              rd_en,
  input  logic [$clog2(MAX_LINE_WIDTH)-1:0] rd_addr,
  input  vconv_pkg::front_t                 front,
  output vconv_pkg::sample_t                window [MAX_TAPS][MAX_TAPS],
  output vconv_pkg::sample_t                coef [MAX_TAPS*MAX_TAPS]
);
  import vconv_pkg::*;

  localparam int CW    = $clog2(MAX_LINE_WIDTH);
  localparam int LSR   = (MAX_TAPS > 1) ? MAX_TAPS - 1 : 1;
  localparam int LW    = LSR * DW;
  localparam int NCOEF = MAX_TAPS * MAX_TAPS;

  logic [LW-1:0] ram_q;
  logic [LW-1:0] rd_col;
  logic [LW-1:0] wr_col;
  logic [LW-1:0] fwd_data;
  logic          fwd_hit;
  logic [CW-1:0] wr_addr;
  sample_t       fresh [MAX_TAPS];

  assign wr_addr = front.col[CW-1:0];

  vconv_ram #(.WIDTH(LW), .DEPTH(MAX_LINE_WIDTH)) u_line (
    .clk  (clk),
    .we   (adv && front.pix_we),
    .waddr(wr_addr),
    .wdata(wr_col),
    .re   (rd_en),
    .raddr(rd_addr),
    .rdata(ram_q)
  );

  // A read issued in the cycle the same column is written returns stale data.
  assign rd_col = fwd_hit ? fwd_data : ram_q;

  always_comb begin
    fresh[0] = front.data;
    for (int i = 1; i < MAX_TAPS; i++) begin
      fresh[i] = rd_col[(i-1)*DW +: DW];
    end
    wr_col = rd_col;
    wr_col[DW-1:0] = front.data;
    for (int k = 1; k < LSR; k++) begin
      wr_col[k*DW +: DW] = rd_col[(k-1)*DW +: DW];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_hit <= 1'b0;
    end else if (adv) begin
      fwd_hit <= rd_en && front.pix_we && (rd_addr == wr_addr);
    end
    if (adv) begin
      fwd_data <= wr_col;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_TAPS; i++) begin
        for (int j = 0; j < MAX_TAPS; j++) begin
          window[i][j] <= '0;
        end
      end
      for (int s = 0; s < NCOEF; s++) begin
        coef[s] <= '0;
      end
    end else if (adv) begin
      if (front.pix_we) begin
        for (int i = 0; i < MAX_TAPS; i++) begin
          for (int j = MAX_TAPS - 1; j >= 1; j--) begin
            window[i][j] <= window[i][j-1];
          end
          window[i][0] <= fresh[i];
        end
      end
      if (front.coef_we) begin
        coef[front.slot] <= front.data;
      end
    end
  end
endmodule
`default_nettype wire

### rtl/vconv_mac.sv
// Tap multiply-accumulate pipeline: operand select, products, row sums, total.
// Depends on vconv_pkg.
`default_nettype none
module vconv_mac #(
  parameter int MAX_TAPS = 7
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         adv,
  input  logic [$clog2(MAX_TAPS+1)-1:0] kw,
  input  logic [$clog2(MAX_TAPS+1)-1:0] kh,
  input  vconv_pkg::sample_t           window [MAX_TAPS][MAX_TAPS],
  input  vconv_pkg::sample_t           coef [MAX_TAPS*MAX_TAPS],
  input  vconv_pkg::meta_t             meta_in,
  output vconv_pkg::meta_t             meta_out,
  output vconv_pkg::sum_t              sum_out
);
  import vconv_pkg::*;

  localparam int NCOEF = MAX_TAPS * MAX_TAPS;
  localparam int IW    = (NCOEF > 1) ? $clog2(NCOEF) : 1;
  localparam int PW    = 2 * DW;

  sample_t                a_q   [MAX_TAPS][MAX_TAPS];
  sample_t                b_q   [MAX_TAPS][MAX_TAPS];
  sample_t                b_sel [MAX_TAPS][MAX_TAPS];
  logic signed [PW-1:0]   p_q   [MAX_TAPS][MAX_TAPS];
  sum_t                   row_sum [MAX_TAPS];
  sum_t                   row_q   [MAX_TAPS];
  sum_t                   total;
  meta_t                  m_op, m_prod, m_row, m_sum;

  // Window (i,j) pairs with coefficient (kh-1-i)*kw + (kw-1-j).
  always_comb begin
    int unsigned idx;
    idx = 0;
    for (int i = 0; i < MAX_TAPS; i++) begin
      for (int j = 0; j < MAX_TAPS; j++) begin
        idx = (int'(kh) - 1 - i) * int'(kw) + (int'(kw) - 1 - j);
        if (i < int'(kh) && j < int'(kw)) begin
          b_sel[i][j] = coef[IW'(idx)];
        end else begin
          b_sel[i][j] = '0;
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_TAPS; i++) begin
      row_sum[i] = '0;
      for (int j = 0; j < MAX_TAPS; j++) begin
        row_sum[i] = row_sum[i] + SUMW'(p_q[i][j]);
      end
    end
    total = '0;
    for (int i = 0; i < MAX_TAPS; i++) begin
      total = total + row_q[i];
    end
  end

  // Taps outside the kernel drop to zero so stale window entries stay out.
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < MAX_TAPS; i++) begin
        for (int j = 0; j < MAX_TAPS; j++) begin
          a_q[i][j] <= (i < int'(kh) && j < int'(kw)) ? window[i][j] : '0;
          b_q[i][j] <= b_sel[i][j];
          p_q[i][j] <= a_q[i][j] * b_q[i][j];
        end
        row_q[i] <= row_sum[i];
      end
      sum_out <= total;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_op     <= '0;
      m_prod   <= '0;
      m_row    <= '0;
      m_sum    <= '0;
      meta_out <= '0;
    end else if (adv) begin
      m_op     <= meta_in;
      m_prod   <= m_op;
      m_row    <= m_prod;
      m_sum    <= m_row;
      meta_out <= m_sum;
    end
  end
endmodule
`default_nettype wire

### rtl/valid_2d_convolution.sv
// Top level of the valid 2D convolution block: config, raster tracking, front stage.
// Depends on vconv_pkg, vconv_window, vconv_mac, vconv_ram.
`default_nettype none
// Streaming valid (no padding) 2D convolution in correlation form. Write
// kernel coefficients first as words with operation 0 (slot m*taps_wide+n,
// Q2.14), then stream pixels in raster order with operation 1 (Q8.8).
// Result (r,c), an exact Q16.22 sum, leaves when pixel (r+taps_high-1,
// c+taps_wide-1) has gone through, only inside the clamped result size;
// frame_last marks the final result of a frame. One word is taken per
// clock while item_stall is low, whether it makes a result or not; the line
// store is a single RAM, read when a pixel is taken and written back from
// the front stage, with forwarding when consecutive pixels hit the same
// column. The whole pipeline holds while a result waits under result_stall,
// so item_stall follows it directly.
// Change the registers only while the block is idle.
module valid_2d_convolution #(
  parameter int MAX_LINE_WIDTH = 128,
  parameter int MAX_TAPS       = 7
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [vconv_pkg::CFGIW-1:0]       cfg_index,
  input  logic [vconv_pkg::CFGW-1:0]        cfg_data,
  input  logic                              item_valid,
  output logic                              item_stall,
  input  logic                              operation,
  input  logic [vconv_pkg::SLOTW-1:0]       coef_slot,
  input  logic signed [vconv_pkg::DW-1:0]   data_value,
  output logic                              result_valid,
  input  logic                              result_stall,
  output logic [vconv_pkg::ROWW-1:0]        out_row,
  output logic [$clog2(MAX_LINE_WIDTH)-1:0] out_col,
  output logic signed [vconv_pkg::SUMW-1:0] sum_value,
  output logic                              frame_last
);
  import vconv_pkg::*;

  localparam int CW    = $clog2(MAX_LINE_WIDTH);
  localparam int TW    = $clog2(MAX_TAPS + 1);
  localparam int NCOEF = MAX_TAPS * MAX_TAPS;

  // Configuration registers.
  logic [7:0]  image_width;
  logic [10:0] image_height;
  logic [2:0]  taps_wide;
  logic [2:0]  taps_high;
  logic [7:0]  result_width;
  logic [10:0] result_height;

  // Effective geometry, 16 bits wide for headroom.
  logic [15:0] w, h, kw, kh, rw, rh;

  // Raster position of the next pixel.
  logic [ROWW-1:0] pix_row;
  logic [CW-1:0]   pix_col;

  // Front stage: the word taken last, waiting for its line store read.
  logic            s1_valid;
  logic            s1_op;
  logic [SLOTW-1:0] s1_slot;
  sample_t         s1_data;
  logic [ROWW-1:0] s1_row;
  logic [CW-1:0]   s1_col;

  logic    adv;
  logic    accept;
  logic    rd_en;
  logic [15:0] row16, col16, r16, c16;
  front_t  front;
  meta_t   meta_s1;
  meta_t   meta_out;
  sample_t window [MAX_TAPS][MAX_TAPS];
  sample_t coef [NCOEF];

  // Advance everything unless a finished result is held.
  assign adv        = !(result_valid && result_stall);
  assign item_stall = !adv;
  assign accept     = item_valid && adv;
  assign rd_en      = accept && (operation == OP_PIXEL);

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width   <= 8'd128;
      image_height  <= 11'd128;
      taps_wide     <= 3'd3;
      taps_high     <= 3'd3;
      result_width  <= 8'd126;
      result_height <= 11'd126;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_IMAGE_WIDTH:   image_width   <= cfg_data[7:0];
        CFG_IMAGE_HEIGHT:  image_height  <= cfg_data;
        CFG_TAPS_WIDE:     taps_wide     <= cfg_data[2:0];
        CFG_TAPS_HIGH:     taps_high     <= cfg_data[2:0];
        CFG_RESULT_WIDTH:  result_width  <= cfg_data[7:0];
        CFG_RESULT_HEIGHT: result_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Saturate out-of-range registers, then clamp the result size.
  always_comb begin
    w  = (image_width == '0) ? 16'd1 :
         ((16'(image_width) > 16'(MAX_LINE_WIDTH)) ? 16'(MAX_LINE_WIDTH)
                                                   : 16'(image_width));
    h  = (image_height == '0) ? 16'd1 :
         ((16'(image_height) > 16'(ROW_LIMIT)) ? 16'(ROW_LIMIT) : 16'(image_height));
    kw = (taps_wide == '0) ? 16'd1 :
         ((16'(taps_wide) > 16'(MAX_TAPS)) ? 16'(MAX_TAPS) : 16'(taps_wide));
    kh = (taps_high == '0) ? 16'd1 :
         ((16'(taps_high) > 16'(MAX_TAPS)) ? 16'(MAX_TAPS) : 16'(taps_high));
    rw = (w >= kw) ? w - kw + 16'd1 : 16'd0;
    rh = (h >= kh) ? h - kh + 16'd1 : 16'd0;
    if (16'(result_width) < rw) begin
      rw = 16'(result_width);
    end
    if (16'(result_height) < rh) begin
      rh = 16'(result_height);
    end
  end

  // Advance the raster on every pixel; wrap column, then row.
  always_ff @(posedge clk) begin
    if (rst) begin
      pix_row <= '0;
      pix_col <= '0;
    end else if (rd_en) begin
      if (16'(pix_col) + 16'd1 >= w) begin
        pix_col <= '0;
        pix_row <= (16'(pix_row) + 16'd1 >= h) ? '0 : pix_row + ROWW'(1);
      end else begin
        pix_col <= pix_col + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= accept;
    end
    if (adv) begin
      s1_op   <= operation;
      s1_slot <= coef_slot;
      s1_data <= data_value;
      s1_row  <= pix_row;
      s1_col  <= pix_col;
    end
  end

  // Decide whether this pixel completes a window inside the result area.
  always_comb begin
    row16 = 16'(s1_row);
    col16 = 16'(s1_col);
    r16   = row16 + 16'd1 - kh;
    c16   = col16 + 16'd1 - kw;
    meta_s1.valid = s1_valid && (s1_op == OP_PIXEL) &&
                    (row16 + 16'd1 >= kh) && (col16 + 16'd1 >= kw) &&
                    (r16 < rh) && (c16 < rw);
    meta_s1.row  = r16[ROWW-1:0];
    meta_s1.col  = c16[COLMAXW-1:0];
    meta_s1.last = (r16 == rh - 16'd1) && (c16 == rw - 16'd1);
  end

  always_comb begin
    front.pix_we  = s1_valid && (s1_op == OP_PIXEL);
    front.coef_we = s1_valid && (s1_op == OP_COEF) && (16'(s1_slot) < 16'(NCOEF));
    front.slot    = s1_slot;
    front.col     = COLMAXW'(s1_col);
    front.data    = s1_data;
  end

  vconv_window #(.MAX_LINE_WIDTH(MAX_LINE_WIDTH), .MAX_TAPS(MAX_TAPS)) u_window (
    .clk    (clk),
    .rst    (rst),
    .adv    (adv),
    .rd_en  (rd_en),
    .rd_addr(pix_col),
    .front  (front),
    .window (window),
    .coef   (coef)
  );

  vconv_mac #(.MAX_TAPS(MAX_TAPS)) u_mac (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .kw      (kw[TW-1:0]),
    .kh      (kh[TW-1:0]),
    .window  (window),
    .coef    (coef),
    .meta_in (meta_s1),
    .meta_out(meta_out),
    .sum_out (sum_value)
  );

  assign result_valid = meta_out.valid;
  assign out_row      = meta_out.row;
  assign out_col      = meta_out.col[CW-1:0];
  assign frame_last   = meta_out.last;
endmodule
`default_nettype wire

### rtl/vconv_checker.sv
// Port-level checker for the valid 2D convolution block, bound to the top level.
// Depends on valid_2d_convolution_macros.svh and vconv_pkg.
`default_nettype none
`include "valid_2d_convolution_macros.svh"
module vconv_checker #(
  parameter int MAX_LINE_WIDTH = 128
) (
  input logic                              clk,
  input logic                              rst,
  input logic                              item_stall,
  input logic                              result_valid,
  input logic                              result_stall,
  input logic [vconv_pkg::ROWW-1:0]        out_row,
  input logic [$clog2(MAX_LINE_WIDTH)-1:0] out_col,
  input logic signed [vconv_pkg::SUMW-1:0] sum_value,
  input logic                              frame_last
);
  `VCONV_CHECK(a_result_hold, (result_valid && result_stall) |=> (result_valid && $stable(out_row) && $stable(out_col) && $stable(sum_value) && $stable(frame_last)), "held result word changed")
  `VCONV_CHECK(a_stall_tracks_output, item_stall == (result_valid && result_stall), "input stall does not follow blocked output")
  `VCONV_ALWAYS(a_reset_empty, rst |=> !result_valid, "result word present after reset")
endmodule

bind valid_2d_convolution vconv_checker #(.MAX_LINE_WIDTH(MAX_LINE_WIDTH)) u_vconv_checker (.*);
`default_nettype wire
